[design/pva_pkg.sv]
`default_nettype none

package pva_pkg;

    localparam int OP_W          = 3;
    localparam int NOTE_W        = 7;
    localparam int VEL_W         = 7;
    localparam int PATCH_W       = 4;
    localparam int MASK_W        = 16;
    localparam int ENDED_W       = 4;
    localparam int VOICE_IDX_W   = 4;
    localparam int AGE_W         = 32;
    localparam int MAX_RESULTS   = 16;
    localparam int CNT_W         = $clog2(MAX_RESULTS + 1);

    localparam logic [OP_W-1:0] OP_NOTE_ON     = 3'd0;
    localparam logic [OP_W-1:0] OP_NOTE_OFF    = 3'd1;
    localparam logic [OP_W-1:0] OP_PEDAL       = 3'd2;
    localparam logic [OP_W-1:0] OP_ALL_OFF     = 3'd3;
    localparam logic [OP_W-1:0] OP_VOICE_ENDED = 3'd4;

    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef enum logic [2:0] {
        SK_NONE,
        SK_NOTE_ON,
        SK_RELEASE,
        SK_PEDAL_UP,
        SK_ALL_OFF
    } scan_kind_t;

    typedef struct packed {
        logic load;
        logic prime;
        logic step;
        logic place;
        logic flush;
    } pva_cmd_t;

    typedef struct packed {
        logic needs_scan;
        logic note_on;
        logic scan_last;
        logic step_ready;
        logic flush_ready;
    } pva_stat_t;

endpackage

`default_nettype wire

[design/pva_ram.sv]
`default_nettype none

module pva_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

[design/pva_ctrl.sv]
`default_nettype none

module pva_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire pva_pkg::pva_stat_t stat,
    output pva_pkg::pva_cmd_t       cmd
);

    import pva_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRIME,
        ST_SCAN,
        ST_PLACE,
        ST_FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_PRIME;
                end
            end
            ST_PRIME:
            begin
                // issue the read of voice 0; requests without a scan end here
                cmd.prime  = 1'b1;
                state_next = stat.needs_scan ? ST_SCAN : ST_IDLE;
            end
            ST_SCAN:
            begin
                if (stat.step_ready)
                begin
                    cmd.step = 1'b1;
                    if (stat.scan_last)
                    begin
                        state_next = stat.note_on ? ST_PLACE : ST_FLUSH;
                    end
                end
            end
            ST_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = ST_FLUSH;
            end
            ST_FLUSH:
            begin
                if (stat.flush_ready)
                begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[design/pva_datapath.sv]
`default_nettype none

module pva_datapath #(
    parameter int VOICE_COUNT = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire pva_pkg::pva_cmd_t           cmd,
    output pva_pkg::pva_stat_t               stat,
    input  wire logic [pva_pkg::OP_W-1:0]    op,
    input  wire logic [pva_pkg::NOTE_W-1:0]  note,
    input  wire logic [pva_pkg::VEL_W-1:0]   velocity,
    input  wire logic [pva_pkg::PATCH_W-1:0] patch_slot,
    input  wire logic                        pedal_on,
    input  wire logic [pva_pkg::MASK_W-1:0]  idle_mask,
    input  wire logic [pva_pkg::ENDED_W-1:0] ended_voice,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic                             cmd_out,
    output logic [pva_pkg::VOICE_IDX_W-1:0]  voice_index,
    output logic [pva_pkg::NOTE_W-1:0]       out_note,
    output logic [pva_pkg::VEL_W-1:0]        out_velocity,
    output logic [pva_pkg::PATCH_W-1:0]      out_patch,
    output logic                             last
);

    import pva_pkg::*;

    localparam int VW = $clog2(VOICE_COUNT);

    // voice state
    logic [VOICE_COUNT-1:0] active_reg, active_next;
    logic [VOICE_COUNT-1:0] sus_reg, sus_next;
    logic                   pedal_reg, pedal_next;
    logic [AGE_W-1:0]       age_clock_reg, age_clock_next;

    // latched request
    scan_kind_t             kind_reg, kind_next;
    logic [NOTE_W-1:0]      nt_reg, nt_next;
    logic [VEL_W-1:0]       vel_reg, vel_next;
    logic [PATCH_W-1:0]     patch_reg, patch_next;
    logic [VOICE_COUNT-1:0] idle_reg, idle_next;

    // scan
    logic [VW-1:0]          idx_reg, idx_next;
    logic                   free_found_reg, free_found_next;
    logic [VW-1:0]          free_idx_reg, free_idx_next;
    logic                   idle_found_reg, idle_found_next;
    logic [VW-1:0]          idle_idx_reg, idle_idx_next;
    logic [VW-1:0]          best_idx_reg, best_idx_next;
    logic [AGE_W-1:0]       best_age_reg, best_age_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;

    // pending command, held until the next one shows whether it is the last
    logic                   pend_valid_reg, pend_valid_next;
    logic                   pend_cmd_reg, pend_cmd_next;
    logic [VW-1:0]          pend_voice_reg, pend_voice_next;
    logic [NOTE_W-1:0]      pend_note_reg, pend_note_next;
    logic [VEL_W-1:0]       pend_vel_reg, pend_vel_next;
    logic [PATCH_W-1:0]     pend_patch_reg, pend_patch_next;

    // output stage
    logic                   out_valid_reg, out_valid_next;
    logic                   out_cmd_reg, out_cmd_next;
    logic [VW-1:0]          out_voice_reg, out_voice_next;
    logic [NOTE_W-1:0]      out_note_reg, out_note_next;
    logic [VEL_W-1:0]       out_vel_reg, out_vel_next;
    logic [PATCH_W-1:0]     out_patch_reg, out_patch_next;
    logic                   out_last_reg, out_last_next;

    logic [VOICE_COUNT-1:0] idle_vec;
    logic [NOTE_W-1:0]      note_q;
    logic [AGE_W-1:0]       age_q;
    logic [VW-1:0]          rd_addr;
    logic                   rd_en;
    logic                   wr_en;
    logic [VW-1:0]          chosen;
    logic                   act;
    logic                   sus_cur;
    logic                   match;
    logic                   emit_want;
    logic                   cnt_full;
    logic                   out_free;
    logic                   out_load;
    logic                   out_last;
    logic                   free_after;

    // voices above the mask width never count as idle
    always_comb
    begin
        for (int v = 0; v < VOICE_COUNT; v++)
        begin
            idle_vec[v] = (v < MASK_W) ? idle_mask[v % MASK_W] : 1'b0;
        end
    end

    assign rd_en   = cmd.prime | cmd.step;
    assign rd_addr = cmd.prime ? '0 : VW'(idx_reg + 1'b1);
    assign wr_en   = cmd.place;
    assign chosen  = free_found_reg ? free_idx_reg :
                     idle_found_reg ? idle_idx_reg : best_idx_reg;

    pva_ram #(
        .WIDTH (NOTE_W),
        .DEPTH (VOICE_COUNT)
    ) u_note_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (chosen),
        .wr_data (nt_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (note_q)
    );

    pva_ram #(
        .WIDTH (AGE_W),
        .DEPTH (VOICE_COUNT)
    ) u_age_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (chosen),
        .wr_data (AGE_W'(age_clock_reg + 1'b1)),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (age_q)
    );

    assign act        = active_reg[idx_reg];
    assign sus_cur    = sus_reg[idx_reg];
    assign match      = act && (note_q == nt_reg);
    assign free_after = !act || match;
    assign cnt_full   = (cnt_reg == CNT_W'(MAX_RESULTS));
    assign out_free   = !out_valid_reg || !out_stall;

    always_comb
    begin
        case (kind_reg)
            SK_RELEASE:  emit_want = match && !pedal_reg;
            SK_PEDAL_UP: emit_want = act && sus_cur;
            SK_ALL_OFF:  emit_want = act;
            default:     emit_want = 1'b0;
        endcase
    end

    always_comb
    begin
        stat.needs_scan  = (kind_reg != SK_NONE);
        stat.note_on     = (kind_reg == SK_NOTE_ON);
        stat.scan_last   = (idx_reg == VW'(VOICE_COUNT - 1));
        stat.step_ready  = !emit_want || cnt_full || !pend_valid_reg || out_free;
        stat.flush_ready = !pend_valid_reg || out_free;
    end

    always_comb
    begin
        active_next     = active_reg;
        sus_next        = sus_reg;
        pedal_next      = pedal_reg;
        age_clock_next  = age_clock_reg;
        kind_next       = kind_reg;
        nt_next         = nt_reg;
        vel_next        = vel_reg;
        patch_next      = patch_reg;
        idle_next       = idle_reg;
        idx_next        = idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        idle_found_next = idle_found_reg;
        idle_idx_next   = idle_idx_reg;
        best_idx_next   = best_idx_reg;
        best_age_next   = best_age_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_cmd_next   = pend_cmd_reg;
        pend_voice_next = pend_voice_reg;
        pend_note_next  = pend_note_reg;
        pend_vel_next   = pend_vel_reg;
        pend_patch_next = pend_patch_reg;
        out_load        = 1'b0;
        out_last        = 1'b0;

        if (cmd.load)
        begin
            nt_next    = note;
            vel_next   = velocity;
            patch_next = patch_slot;
            idle_next  = idle_vec;
            cnt_next   = '0;
            if (op == OP_NOTE_ON && velocity != '0)
            begin
                kind_next = SK_NOTE_ON;
            end
            else if (op == OP_NOTE_ON || op == OP_NOTE_OFF)
            begin
                kind_next = SK_RELEASE;
            end
            else if (op == OP_PEDAL)
            begin
                pedal_next = pedal_on;
                kind_next  = pedal_on ? SK_NONE : SK_PEDAL_UP;
            end
            else if (op == OP_ALL_OFF)
            begin
                pedal_next = 1'b0;
                kind_next  = SK_ALL_OFF;
            end
            else
            begin
                kind_next = SK_NONE;
                if (op == OP_VOICE_ENDED)
                begin
                    for (int v = 0; v < VOICE_COUNT; v++)
                    begin
                        if (32'(ended_voice) == v)
                        begin
                            active_next[v] = 1'b0;
                            sus_next[v]    = 1'b0;
                        end
                    end
                end
            end
        end

        if (cmd.prime)
        begin
            idx_next        = '0;
            free_found_next = 1'b0;
            idle_found_next = 1'b0;
        end

        if (cmd.step)
        begin
            idx_next = VW'(idx_reg + 1'b1);
            case (kind_reg)
                SK_NOTE_ON:
                begin
                    // drop a voice already holding this note, silently
                    if (match)
                    begin
                        active_next[idx_reg] = 1'b0;
                        sus_next[idx_reg]    = 1'b0;
                    end
                    if (free_after && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = idx_reg;
                    end
                    if (idle_reg[idx_reg] && !idle_found_reg)
                    begin
                        idle_found_next = 1'b1;
                        idle_idx_next   = idx_reg;
                    end
                    if (idx_reg == '0 || age_q < best_age_reg)
                    begin
                        best_idx_next = idx_reg;
                        best_age_next = age_q;
                    end
                end
                SK_RELEASE:
                begin
                    if (match && pedal_reg)
                    begin
                        sus_next[idx_reg] = 1'b1;
                    end
                end
                SK_PEDAL_UP:
                begin
                    if (act && sus_cur)
                    begin
                        sus_next[idx_reg] = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
            if (emit_want && !cnt_full)
            begin
                // push the held command out before taking the new one
                if (pend_valid_reg)
                begin
                    out_load = 1'b1;
                end
                pend_valid_next = 1'b1;
                pend_cmd_next   = CMD_RELEASE;
                pend_voice_next = idx_reg;
                pend_note_next  = note_q;
                pend_vel_next   = '0;
                pend_patch_next = '0;
                cnt_next        = CNT_W'(cnt_reg + 1'b1);
            end
        end

        if (cmd.place)
        begin
            active_next[chosen] = 1'b1;
            sus_next[chosen]    = 1'b0;
            age_clock_next      = AGE_W'(age_clock_reg + 1'b1);
            pend_valid_next     = 1'b1;
            pend_cmd_next       = CMD_START;
            pend_voice_next     = chosen;
            pend_note_next      = nt_reg;
            pend_vel_next       = vel_reg;
            pend_patch_next     = patch_reg;
            cnt_next            = CNT_W'(cnt_reg + 1'b1);
        end

        if (cmd.flush && pend_valid_reg)
        begin
            out_load        = 1'b1;
            out_last        = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        out_cmd_next   = out_cmd_reg;
        out_voice_next = out_voice_reg;
        out_note_next  = out_note_reg;
        out_vel_next   = out_vel_reg;
        out_patch_next = out_patch_reg;
        out_last_next  = out_last_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_cmd_next   = pend_cmd_reg;
            out_voice_next = pend_voice_reg;
            out_note_next  = pend_note_reg;
            out_vel_next   = pend_vel_reg;
            out_patch_next = pend_patch_reg;
            out_last_next  = out_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= '0;
            sus_reg        <= '0;
            pedal_reg      <= 1'b0;
            age_clock_reg  <= '0;
            kind_reg       <= SK_NONE;
            idx_reg        <= '0;
            free_found_reg <= 1'b0;
            idle_found_reg <= 1'b0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            active_reg     <= active_next;
            sus_reg        <= sus_next;
            pedal_reg      <= pedal_next;
            age_clock_reg  <= age_clock_next;
            kind_reg       <= kind_next;
            idx_reg        <= idx_next;
            free_found_reg <= free_found_next;
            idle_found_reg <= idle_found_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nt_reg         <= nt_next;
        vel_reg        <= vel_next;
        patch_reg      <= patch_next;
        idle_reg       <= idle_next;
        free_idx_reg   <= free_idx_next;
        idle_idx_reg   <= idle_idx_next;
        best_idx_reg   <= best_idx_next;
        best_age_reg   <= best_age_next;
        pend_cmd_reg   <= pend_cmd_next;
        pend_voice_reg <= pend_voice_next;
        pend_note_reg  <= pend_note_next;
        pend_vel_reg   <= pend_vel_next;
        pend_patch_reg <= pend_patch_next;
        out_cmd_reg    <= out_cmd_next;
        out_voice_reg  <= out_voice_next;
        out_note_reg   <= out_note_next;
        out_vel_reg    <= out_vel_next;
        out_patch_reg  <= out_patch_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid    = out_valid_reg;
    assign cmd_out      = out_cmd_reg;
    assign voice_index  = VOICE_IDX_W'(out_voice_reg);
    assign out_note     = out_note_reg;
    assign out_velocity = out_vel_reg;
    assign out_patch    = out_patch_reg;
    assign last         = out_last_reg;

endmodule

`default_nettype wire

[design/polyphonic_voice_allocator_unit.sv]
`default_nettype none

// Voice allocator: turns note-on, note-off, pedal, all-off and voice-ended
// requests into start and release commands for VOICE_COUNT voices, stealing
// the oldest voice when none is free or idle. One request is handled at a
// time. Pedal-down, voice-ended and unused ops end after the prime step
// without a scan. Note-on, note-off, pedal-up and all-off walk the voice
// table once through the note and age memories, one voice per cycle while
// the result channel does not stall. Results leave through a single output
// register, and the flag last marks the final command of each request; at
// most 16 commands are issued per request.
module polyphonic_voice_allocator_unit #(
    parameter int VOICE_COUNT = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [pva_pkg::OP_W-1:0]    op,
    input  wire logic [pva_pkg::NOTE_W-1:0]  note,
    input  wire logic [pva_pkg::VEL_W-1:0]   velocity,
    input  wire logic [pva_pkg::PATCH_W-1:0] patch_slot,
    input  wire logic                        pedal_on,
    input  wire logic [pva_pkg::MASK_W-1:0]  idle_mask,
    input  wire logic [pva_pkg::ENDED_W-1:0] ended_voice,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic                             cmd,
    output logic [pva_pkg::VOICE_IDX_W-1:0]  voice_index,
    output logic [pva_pkg::NOTE_W-1:0]       out_note,
    output logic [pva_pkg::VEL_W-1:0]        out_velocity,
    output logic [pva_pkg::PATCH_W-1:0]      out_patch,
    output logic                             last
);

    import pva_pkg::*;

    pva_cmd_t  ctl_cmd;
    pva_stat_t dp_stat;

    pva_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (dp_stat),
        .cmd      (ctl_cmd)
    );

    pva_datapath #(
        .VOICE_COUNT (VOICE_COUNT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (ctl_cmd),
        .stat         (dp_stat),
        .op           (op),
        .note         (note),
        .velocity     (velocity),
        .patch_slot   (patch_slot),
        .pedal_on     (pedal_on),
        .idle_mask    (idle_mask),
        .ended_voice  (ended_voice),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .cmd_out      (cmd),
        .voice_index  (voice_index),
        .out_note     (out_note),
        .out_velocity (out_velocity),
        .out_patch    (out_patch),
        .last         (last)
    );

endmodule

`default_nettype wire

[test/polyphonic_voice_allocator_unit_tb.sv]
module polyphonic_voice_allocator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pva_pkg::*;

    localparam int VOICES       = 16;
    localparam int CLK_PERIOD   = 10;
    localparam int IDLE_PCT     = 26;
    localparam int HOLD_CYCLES  = 250;
    localparam int SETTLE       = VOICES + 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [NOTE_W-1:0]  note;
        logic [VEL_W-1:0]   velocity;
        logic [PATCH_W-1:0] patch_slot;
        logic               pedal_on;
        logic [MASK_W-1:0]  idle_mask;
        logic [ENDED_W-1:0] ended_voice;
    } request_t;

    typedef struct packed {
        logic                   cmd;
        logic [VOICE_IDX_W-1:0] voice_index;
        logic [NOTE_W-1:0]      out_note;
        logic [VEL_W-1:0]       out_velocity;
        logic [PATCH_W-1:0]     out_patch;
        logic                   last;
    } command_t;

    class voice_scoreboard;
        bit               active [VOICES];
        bit               sustained [VOICES];
        logic [NOTE_W-1:0] held_note [VOICES];
        logic [AGE_W-1:0]  age [VOICES];
        logic [AGE_W-1:0]  age_clock;
        bit               pedal_down;
        command_t         batch [$];
        command_t         expected_cmds [$];
        int               failures;

        function new();
            foreach (active[v])
            begin
                active[v]    = 1'b0;
                sustained[v] = 1'b0;
                held_note[v] = '0;
                age[v]       = '0;
            end
            age_clock  = '0;
            pedal_down = 1'b0;
            failures   = 0;
        endfunction

        // Commands beyond the cap are dropped; the state still moves on.
        function void add_command(logic c, int v, logic [NOTE_W-1:0] n,
                                  logic [VEL_W-1:0] vel, logic [PATCH_W-1:0] patch);
            command_t c_item;
            if (batch.size() >= MAX_RESULTS)
                return;
            c_item.cmd          = c;
            c_item.voice_index  = v[VOICE_IDX_W-1:0];
            c_item.out_note     = n;
            c_item.out_velocity = vel;
            c_item.out_patch    = patch;
            c_item.last         = 1'b0;
            batch.push_back(c_item);
        endfunction

        function void note_request(request_t r);
            int pick;
            batch.delete();
            if (r.op == OP_NOTE_ON && r.velocity != 0)
            begin
                for (int v = 0; v < VOICES; v++)
                begin
                    if (active[v] && held_note[v] == r.note)
                    begin
                        active[v]    = 1'b0;
                        sustained[v] = 1'b0;
                    end
                end
                pick = -1;
                for (int v = 0; v < VOICES; v++)
                    if (pick < 0 && !active[v])
                        pick = v;
                for (int v = 0; v < VOICES && v < MASK_W; v++)
                    if (pick < 0 && r.idle_mask[v])
                        pick = v;
                if (pick < 0)
                begin
                    // steal the oldest, lowest index on a tie
                    pick = 0;
                    for (int v = 1; v < VOICES; v++)
                        if (age[v] < age[pick])
                            pick = v;
                end
                held_note[pick] = r.note;
                sustained[pick] = 1'b0;
                age_clock       = age_clock + 1;
                age[pick]       = age_clock;
                active[pick]    = 1'b1;
                add_command(CMD_START, pick, r.note, r.velocity, r.patch_slot);
            end
            else if (r.op == OP_NOTE_ON || r.op == OP_NOTE_OFF)
            begin
                for (int v = 0; v < VOICES; v++)
                begin
                    if (active[v] && held_note[v] == r.note)
                    begin
                        if (pedal_down)
                            sustained[v] = 1'b1;
                        else
                            add_command(CMD_RELEASE, v, held_note[v], '0, '0);
                    end
                end
            end
            else if (r.op == OP_PEDAL)
            begin
                pedal_down = r.pedal_on;
                if (!r.pedal_on)
                begin
                    for (int v = 0; v < VOICES; v++)
                    begin
                        if (active[v] && sustained[v])
                        begin
                            sustained[v] = 1'b0;
                            add_command(CMD_RELEASE, v, held_note[v], '0, '0);
                        end
                    end
                end
            end
            else if (r.op == OP_ALL_OFF)
            begin
                for (int v = 0; v < VOICES; v++)
                    if (active[v])
                        add_command(CMD_RELEASE, v, held_note[v], '0, '0);
                pedal_down = 1'b0;
            end
            else if (r.op == OP_VOICE_ENDED)
            begin
                if (r.ended_voice < VOICES)
                begin
                    active[r.ended_voice]    = 1'b0;
                    sustained[r.ended_voice] = 1'b0;
                end
            end
            if (batch.size() > 0)
                batch[batch.size() - 1].last = 1'b1;
            foreach (batch[i])
                expected_cmds.push_back(batch[i]);
        endfunction

        function void check_command(command_t got);
            command_t want;
            if (expected_cmds.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("%0t: unexpected command cmd=%0d voice=%0d note=%0d",
                             $realtime, got.cmd, got.voice_index, got.out_note,
                             "  vel=%0d patch=%0d last=%0d",
                             got.out_velocity, got.out_patch, got.last);
                return;
            end
            want = expected_cmds.pop_front();
            if (got.cmd !== want.cmd || got.voice_index !== want.voice_index ||
                got.out_note !== want.out_note || got.out_velocity !== want.out_velocity ||
                got.out_patch !== want.out_patch || got.last !== want.last)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                begin
                    $display("%0t: command mismatch", $realtime);
                    $display("  expected cmd=%0d voice=%0d note=%0d vel=%0d patch=%0d last=%0d",
                             want.cmd, want.voice_index, want.out_note,
                             want.out_velocity, want.out_patch, want.last);
                    $display("  actual   cmd=%0d voice=%0d note=%0d vel=%0d patch=%0d last=%0d",
                             got.cmd, got.voice_index, got.out_note,
                             got.out_velocity, got.out_patch, got.last);
                end
            end
        endfunction

        function int pending();
            return expected_cmds.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [OP_W-1:0]        op;
    logic [NOTE_W-1:0]      note;
    logic [VEL_W-1:0]       velocity;
    logic [PATCH_W-1:0]     patch_slot;
    logic                   pedal_on;
    logic [MASK_W-1:0]      idle_mask;
    logic [ENDED_W-1:0]     ended_voice;
    logic                   out_valid;
    logic                   out_stall;
    logic                   cmd;
    logic [VOICE_IDX_W-1:0] voice_index;
    logic [NOTE_W-1:0]      out_note;
    logic [VEL_W-1:0]       out_velocity;
    logic [PATCH_W-1:0]     out_patch;
    logic                   last;

    voice_scoreboard sb = new();
    bit              steady = 1'b0;
    bit              hold_request = 1'b0;
    int unsigned     cycle_count = 0;
    int              note_base = 0;

    polyphonic_voice_allocator_unit #(
        .VOICE_COUNT (VOICES)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .note         (note),
        .velocity     (velocity),
        .patch_slot   (patch_slot),
        .pedal_on     (pedal_on),
        .idle_mask    (idle_mask),
        .ended_voice  (ended_voice),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .cmd          (cmd),
        .voice_index  (voice_index),
        .out_note     (out_note),
        .out_velocity (out_velocity),
        .out_patch    (out_patch),
        .last         (last)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_request('{op, note, velocity, patch_slot, pedal_on,
                              idle_mask, ended_voice});
        if (rst_n && out_valid && !out_stall)
            sb.check_command('{cmd, voice_index, out_note, out_velocity,
                               out_patch, last});
    end

    // Receiver: random stalls, none in steady stretches, and one long hold-off.
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (steady)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    function automatic request_t make_req(logic [OP_W-1:0] o, int n, int vel, int patch,
                                          bit ped, int mask, int ended);
        request_t r;
        r.op          = o;
        r.note        = n[NOTE_W-1:0];
        r.velocity    = vel[VEL_W-1:0];
        r.patch_slot  = patch[PATCH_W-1:0];
        r.pedal_on    = ped;
        r.idle_mask   = mask[MASK_W-1:0];
        r.ended_voice = ended[ENDED_W-1:0];
        return r;
    endfunction

    task automatic send_request(request_t r);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= r.op;
        note        <= r.note;
        velocity    <= r.velocity;
        patch_slot  <= r.patch_slot;
        pedal_on    <= r.pedal_on;
        idle_mask   <= r.idle_mask;
        ended_voice <= r.ended_voice;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    function automatic request_t random_request(int base);
        request_t r;
        int sel;
        r.op          = $urandom;
        r.note        = $urandom;
        r.velocity    = $urandom;
        r.patch_slot  = $urandom;
        r.pedal_on    = $urandom;
        r.idle_mask   = $urandom;
        r.ended_voice = $urandom;
        sel = $urandom_range(0, 99);
        if (sel < 45)
        begin
            r.op = OP_NOTE_ON;
            if ($urandom_range(0, 9) != 0)
                r.note = base + $urandom_range(0, 23);
            if ($urandom_range(0, 9) == 0)
                r.velocity = '0;
            if ($urandom_range(0, 1) != 0)
                r.idle_mask = '0;
        end
        else if (sel < 70)
        begin
            r.op   = OP_NOTE_OFF;
            r.note = base + $urandom_range(0, 23);
        end
        else if (sel < 80)
            r.op = OP_PEDAL;
        else if (sel < 84)
            r.op = OP_ALL_OFF;
        else if (sel < 94)
            r.op = OP_VOICE_ENDED;
        else
            r.op = $urandom_range(OP_VOICE_ENDED + 1, 7);
        return r;
    endfunction

    // Unused ops go through but do not count towards the total.
    task automatic run_random(int count);
        request_t r;
        int done;
        done = 0;
        while (done < count)
        begin
            if (done % 50 == 0)
                note_base = $urandom_range(0, 104);
            r = random_request(note_base);
            send_request(r);
            if (r.op <= OP_VOICE_ENDED)
                done++;
        end
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        op          <= OP_NOTE_ON;
        note        <= '0;
        velocity    <= '0;
        patch_slot  <= '0;
        pedal_on    <= 1'b0;
        idle_mask   <= '0;
        ended_voice <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(make_req(OP_NOTE_ON, 0, 127, 15, 1'b0, 0, 0));
        send_request(make_req(OP_NOTE_ON, 127, 1, 0, 1'b1, 16'hFFFF, 15));
        // same note again: drop the old voice silently, then restart
        send_request(make_req(OP_NOTE_ON, 0, 64, 5, 1'b0, 0, 0));
        // zero velocity acts as a note off, and a second off releases again
        send_request(make_req(OP_NOTE_ON, 127, 0, 9, 1'b0, 0, 0));
        send_request(make_req(OP_NOTE_OFF, 127, 33, 3, 1'b0, 0, 0));
        send_request(make_req(OP_VOICE_ENDED + 1, 55, 55, 7, 1'b1, 16'hFFFF, 15));
        send_request(make_req(3'd7, 127, 127, 15, 1'b1, 16'hFFFF, 15));
        for (int i = 0; i < VOICES - 2; i++)
            send_request(make_req(OP_NOTE_ON, 40 + i, 1 + 9 * i, i, 1'b0, 16'hFFFF, 0));
        // all voices busy: idle mask first, then steal the oldest
        send_request(make_req(OP_NOTE_ON, 100, 90, 12, 1'b0, 16'h8000, 0));
        send_request(make_req(OP_NOTE_ON, 101, 91, 13, 1'b0, 16'h0000, 0));
        send_request(make_req(OP_PEDAL, 0, 0, 0, 1'b1, 0, 0));
        send_request(make_req(OP_NOTE_OFF, 40, 0, 0, 1'b0, 0, 0));
        // all off lifts the pedal but keeps the sustained flag
        send_request(make_req(OP_ALL_OFF, 0, 0, 0, 1'b0, 0, 0));
        send_request(make_req(OP_PEDAL, 0, 0, 0, 1'b0, 0, 0));
        send_request(make_req(OP_VOICE_ENDED, 0, 0, 0, 1'b0, 0, 15));
        send_request(make_req(OP_VOICE_ENDED, 0, 0, 0, 1'b0, 0, 0));

        run_random(90);

        // hold the result side and keep offering so the block backs up
        steady       = 1'b1;
        hold_request = 1'b1;
        for (int i = 0; i < 20; i++)
            send_request(make_req(OP_NOTE_ON, $urandom_range(0, 127), $urandom_range(1, 127),
                                  $urandom, 1'b0, $urandom, $urandom));
        in_valid <= 1'b0;
        wait_drained();

        run_random(60);
        steady = 1'b0;
        run_random(90);
        in_valid <= 1'b0;

        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (sb.pending() != 0)
        begin
            sb.failures++;
            $display("%0d expected commands never arrived", sb.pending());
        end
        if (sb.failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[files.f]
design/pva_pkg.sv
design/pva_ram.sv
design/pva_ctrl.sv
design/pva_datapath.sv
design/polyphonic_voice_allocator_unit.sv
test/polyphonic_voice_allocator_unit_tb.sv
